@@ hdl/ffdl_pkg.sv @@
// Shared types, constants and helper functions for the fractional feedback delay line.
// Used by hdl/fractional_feedback_delay_line.sv; depends on nothing else.

package ffdl_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 24;
    localparam int INDEX_W    = 16;
    localparam int DSAMP_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DEPTH_W    = 5;
    localparam int RATE_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Shared multiplier and accumulator widths
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = SAMPLE_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W + 1;

    // Rounding shifts: interpolation weights are Q0.16, gains are Q1.15
    localparam int INT_SHIFT = 16;
    localparam int MIX_SHIFT = 15;
    localparam int SAT_IN_W  = ACC_W - MIX_SHIFT;

    localparam logic signed [ACC_W-1:0] HALF_INT = ACC_W'(1) <<< (INT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] HALF_MIX = ACC_W'(1) <<< (MIX_SHIFT - 1);

    // Unity values of the weights
    localparam logic [FRAC_W:0]          FRAC_ONE = 17'h10000;
    localparam logic signed [MUL_A_W-1:0] GAIN_ONE = 18'sd32768;

    // Crusher: depth at or above this leaves the wet value alone
    localparam logic [DEPTH_W-1:0] FULL_DEPTH = 5'd23;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_SAMPLES  = 3'd0,
        CFG_DELAY_FRACTION = 3'd1,
        CFG_FEEDBACK_GAIN  = 3'd2,
        CFG_WET_LEVEL      = 3'd3,
        CFG_BIT_DEPTH      = 3'd4,
        CFG_RATE_DIVIDE    = 3'd5
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_REM,
        S_RD0,
        S_RD1,
        S_INT0,
        S_INT1,
        S_INT2,
        S_YN,
        S_FB0,
        S_FB1,
        S_WR,
        S_HOLD,
        S_MIX0,
        S_MIX1,
        S_DONE
    } t_state;

    // Clamp a wide signed value to the 24-bit sample range
    function automatic t_sample sat24(input logic signed [SAT_IN_W-1:0] v);
        t_sample res;
        if (v[SAT_IN_W-1:SAMPLE_W-1] == '0 || v[SAT_IN_W-1:SAMPLE_W-1] == '1) begin
            res = v[SAMPLE_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Truncate toward zero to a multiple of 2^(23 - depth)
    function automatic t_sample crush(input t_sample v, input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0]  sh;
        logic [SAMPLE_W:0]   mag;
        logic [SAMPLE_W:0]   mask;
        logic [SAMPLE_W:0]   kept;
        logic [SAMPLE_W:0]   neg;
        t_sample             res;
        sh   = FULL_DEPTH - depth;
        mag  = v[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {v[SAMPLE_W-1], v}) : {1'b0, v};
        mask = ((SAMPLE_W+1)'(1) << sh) - (SAMPLE_W+1)'(1);
        kept = mag & ~mask;
        neg  = (SAMPLE_W+1)'(0) - kept;
        if (depth >= FULL_DEPTH) begin
            res = v;
        end else if (v[SAMPLE_W-1]) begin
            res = neg[SAMPLE_W-1:0];
        end else begin
            res = kept[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/fractional_feedback_delay_line.sv @@
// Fractional feedback delay line with linear interpolation and a wet-path bitcrusher.
// Depends on hdl/ffdl_pkg.sv (types, constants, saturate and crush functions).
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_ready      | i_sample_in, i_cross_feed_in,
//          |           |                              | i_sample_index
//  out     | source    | o_out_valid / i_out_ready    | o_sample_out
//  cfg     | sink      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Each word runs through the address step, a bit-serial remainder of the read address
// and sample index by the rate divisor over RW = max(clog2(DELAY_DEPTH), 16) bits,
// then the read, interpolation, feedback, write, hold and mix steps around the one
// 18x25 multiplier and the single-read-port store; the next word waits for idle.
// After reset the store is swept to zero, one entry a cycle, before the first input
// word is taken; configuration writes are taken at any time.
// A finished result waits in the output register; the next input word is accepted
// meanwhile, and the sequencer holds in its last step only if that register is full.

module fractional_feedback_delay_line #(
    parameter int unsigned DELAY_DEPTH = 131072
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ffdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic signed [ffdl_pkg::SAMPLE_W-1:0] i_cross_feed_in,
    input  logic [ffdl_pkg::INDEX_W-1:0]        i_sample_index,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ffdl_pkg::SAMPLE_W-1:0] o_sample_out,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int RW     = (AW > ffdl_pkg::INDEX_W) ? AW : ffdl_pkg::INDEX_W;
    localparam int CNT_W  = $clog2(RW);
    localparam int DCMP_W = (AW > ffdl_pkg::DSAMP_W) ? AW : ffdl_pkg::DSAMP_W;
    localparam int XC_EXT = ffdl_pkg::ACC_W - ffdl_pkg::SAMPLE_W - 1 - ffdl_pkg::MIX_SHIFT;

    localparam logic [AW-1:0]     LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [DCMP_W-1:0] LAST_CMP  = DCMP_W'(DELAY_DEPTH - 1);
    localparam logic [AW:0]       DEPTH_EXT = (AW+1)'(DELAY_DEPTH);
    localparam logic [CNT_W-1:0]  REM_LAST  = CNT_W'(RW - 1);

    // Sequencer
    ffdl_pkg::t_state r_state, n_state;

    // Configuration registers
    logic [ffdl_pkg::DSAMP_W-1:0] r_delay_samples;
    logic [ffdl_pkg::FRAC_W-1:0]  r_delay_fraction;
    logic [ffdl_pkg::GAIN_W-1:0]  r_feedback_gain;
    logic [ffdl_pkg::GAIN_W-1:0]  r_wet_level;
    logic [ffdl_pkg::DEPTH_W-1:0] r_bit_depth;
    logic [ffdl_pkg::RATE_W-1:0]  r_rate_divide;

    // Item and datapath registers
    ffdl_pkg::t_sample r_x, r_c, r_y0, r_yn, r_wet, r_rd_data, r_out;
    logic [AW-1:0]     r_wp, r_r, r_clr_addr;
    logic [RW-1:0]     r_r_sr, r_idx_sr;
    logic [ffdl_pkg::RATE_W-1:0] r_rem_r, r_rem_i;
    logic [CNT_W-1:0]  r_rem_cnt;
    logic signed [ffdl_pkg::PROD_W-1:0] r_prod;
    logic signed [ffdl_pkg::ACC_W-1:0]  r_acc;
    logic              r_out_valid;

    // Delay store
    logic [ffdl_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];

    // Combinational signals
    logic                 w_in_acc, w_cfg_acc, w_out_free, w_hold;
    logic [DCMP_W-1:0]    w_d_ext;
    logic [AW-1:0]        w_d, w_r_calc, w_rm1, w_hold_addr, w_rd_addr, w_wr_addr;
    logic [AW:0]          w_r_wide;
    logic                 w_we;
    ffdl_pkg::t_sample    w_wr_data, w_wet_sel;
    logic [ffdl_pkg::RATE_W:0] w_ta, w_ti, w_rate_ext;
    logic [ffdl_pkg::RATE_W:0] w_rem_r_n, w_rem_i_n;
    logic [ffdl_pkg::FRAC_W:0] w_frac_c;
    logic signed [ffdl_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [ffdl_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [ffdl_pkg::PROD_W-1:0]  w_mul;
    logic signed [ffdl_pkg::ACC_W-1:0]   w_prod_ext;
    logic [ffdl_pkg::SAMPLE_W:0]         w_xc;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ffdl_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out;

    // Read position: clamp the delay, subtract from the write pointer, wrap
    assign w_d_ext  = DCMP_W'(r_delay_samples);
    assign w_d      = (w_d_ext > LAST_CMP) ? LAST_ADDR : w_d_ext[AW-1:0];
    assign w_r_wide = {1'b0, r_wp} + ((r_wp >= w_d) ? '0 : DEPTH_EXT) - {1'b0, w_d};
    assign w_r_calc = w_r_wide[AW-1:0];
    assign w_rm1    = (r_r == '0) ? LAST_ADDR : (r_r - AW'(1));
    assign w_hold_addr = r_r - AW'(r_rem_r);

    // One step of the restoring remainder for both the address and the index
    assign w_rate_ext = {1'b0, r_rate_divide};
    assign w_ta       = {r_rem_r, r_r_sr[RW-1]};
    assign w_ti       = {r_rem_i, r_idx_sr[RW-1]};
    assign w_rem_r_n  = (w_ta >= w_rate_ext) ? (w_ta - w_rate_ext) : w_ta;
    assign w_rem_i_n  = (w_ti >= w_rate_ext) ? (w_ti - w_rate_ext) : w_ti;

    // Hold the stored entry on samples the rate divisor skips
    assign w_hold    = (r_rate_divide > ffdl_pkg::RATE_W'(1)) && (r_rem_i != '0);
    assign w_wet_sel = w_hold ? r_rd_data : r_wet;

    assign w_frac_c   = ffdl_pkg::FRAC_ONE - {1'b0, r_delay_fraction};
    assign w_mul      = w_mul_a * w_mul_b;
    assign w_prod_ext = {r_prod[ffdl_pkg::PROD_W-1], r_prod};
    assign w_xc       = {r_x[ffdl_pkg::SAMPLE_W-1], r_x} + {r_c[ffdl_pkg::SAMPLE_W-1], r_c};

    // Next state, store port and multiplier operand selection
    always_comb begin
        n_state   = r_state;
        w_we      = 1'b0;
        w_wr_addr = r_wp;
        w_wr_data = '0;
        w_rd_addr = r_r;
        w_mul_a   = '0;
        w_mul_b   = '0;
        case (r_state)
            ffdl_pkg::S_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ffdl_pkg::S_IDLE;
                end
            end
            ffdl_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = ffdl_pkg::S_ADDR;
                end
            end
            ffdl_pkg::S_ADDR: n_state = ffdl_pkg::S_REM;
            ffdl_pkg::S_REM: begin
                if (r_rem_cnt == REM_LAST) begin
                    n_state = ffdl_pkg::S_RD0;
                end
            end
            ffdl_pkg::S_RD0: n_state = ffdl_pkg::S_RD1;
            ffdl_pkg::S_RD1: begin
                w_rd_addr = w_rm1;
                n_state   = ffdl_pkg::S_INT0;
            end
            ffdl_pkg::S_INT0: begin
                w_mul_a = $signed({2'b00, r_delay_fraction});
                w_mul_b = {r_rd_data[ffdl_pkg::SAMPLE_W-1], r_rd_data};
                n_state = ffdl_pkg::S_INT1;
            end
            ffdl_pkg::S_INT1: begin
                w_mul_a = $signed({1'b0, w_frac_c});
                w_mul_b = {r_y0[ffdl_pkg::SAMPLE_W-1], r_y0};
                n_state = ffdl_pkg::S_INT2;
            end
            ffdl_pkg::S_INT2: n_state = ffdl_pkg::S_YN;
            ffdl_pkg::S_YN:   n_state = ffdl_pkg::S_FB0;
            ffdl_pkg::S_FB0: begin
                w_mul_a = $signed({2'b00, r_feedback_gain});
                w_mul_b = {r_yn[ffdl_pkg::SAMPLE_W-1], r_yn};
                n_state = ffdl_pkg::S_FB1;
            end
            ffdl_pkg::S_FB1: n_state = ffdl_pkg::S_WR;
            ffdl_pkg::S_WR: begin
                w_we      = 1'b1;
                w_wr_data = ffdl_pkg::sat24(r_acc[ffdl_pkg::ACC_W-1:ffdl_pkg::MIX_SHIFT]);
                w_mul_a   = ffdl_pkg::GAIN_ONE - $signed({2'b00, r_wet_level});
                w_mul_b   = {r_x[ffdl_pkg::SAMPLE_W-1], r_x};
                n_state   = ffdl_pkg::S_HOLD;
            end
            ffdl_pkg::S_HOLD: begin
                w_rd_addr = w_hold_addr;
                n_state   = ffdl_pkg::S_MIX0;
            end
            ffdl_pkg::S_MIX0: begin
                w_mul_a = $signed({2'b00, r_wet_level});
                w_mul_b = {w_wet_sel[ffdl_pkg::SAMPLE_W-1], w_wet_sel};
                n_state = ffdl_pkg::S_MIX1;
            end
            ffdl_pkg::S_MIX1: n_state = ffdl_pkg::S_DONE;
            ffdl_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ffdl_pkg::S_IDLE;
                end
            end
            default: n_state = ffdl_pkg::S_CLEAR;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffdl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes, taken in any state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_samples  <= '0;
            r_delay_fraction <= '0;
            r_feedback_gain  <= '0;
            r_wet_level      <= '0;
            r_bit_depth      <= ffdl_pkg::FULL_DEPTH;
            r_rate_divide    <= ffdl_pkg::RATE_W'(1);
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                ffdl_pkg::CFG_DELAY_SAMPLES:  r_delay_samples  <= i_cfg_data;
                ffdl_pkg::CFG_DELAY_FRACTION: r_delay_fraction <= i_cfg_data[ffdl_pkg::FRAC_W-1:0];
                ffdl_pkg::CFG_FEEDBACK_GAIN:  r_feedback_gain  <= i_cfg_data[ffdl_pkg::GAIN_W-1:0];
                ffdl_pkg::CFG_WET_LEVEL:      r_wet_level      <= i_cfg_data[ffdl_pkg::GAIN_W-1:0];
                ffdl_pkg::CFG_BIT_DEPTH:      r_bit_depth      <= i_cfg_data[ffdl_pkg::DEPTH_W-1:0];
                ffdl_pkg::CFG_RATE_DIVIDE:    r_rate_divide    <= i_cfg_data[ffdl_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing sweep, write pointer and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ffdl_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == ffdl_pkg::S_WR) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : (r_wp + AW'(1));
            end
            if (r_state == ffdl_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: capture, remainder steps, shared multiply and accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        case (r_state)
            ffdl_pkg::S_IDLE: begin
                r_x      <= i_sample_in;
                r_c      <= i_cross_feed_in;
                r_idx_sr <= RW'(i_sample_index);
            end
            ffdl_pkg::S_ADDR: begin
                r_r       <= w_r_calc;
                r_r_sr    <= RW'(w_r_calc);
                r_rem_r   <= '0;
                r_rem_i   <= '0;
                r_rem_cnt <= '0;
            end
            ffdl_pkg::S_REM: begin
                r_rem_r   <= w_rem_r_n[ffdl_pkg::RATE_W-1:0];
                r_rem_i   <= w_rem_i_n[ffdl_pkg::RATE_W-1:0];
                r_r_sr    <= r_r_sr << 1;
                r_idx_sr  <= r_idx_sr << 1;
                r_rem_cnt <= r_rem_cnt + CNT_W'(1);
            end
            ffdl_pkg::S_RD1:  r_y0  <= r_rd_data;
            ffdl_pkg::S_INT1: r_acc <= w_prod_ext + ffdl_pkg::HALF_INT;
            ffdl_pkg::S_INT2: r_acc <= r_acc + w_prod_ext;
            ffdl_pkg::S_YN: begin
                r_yn <= (r_delay_samples == '0) ? r_x
                                                : r_acc[ffdl_pkg::INT_SHIFT +: ffdl_pkg::SAMPLE_W];
            end
            ffdl_pkg::S_FB1: begin
                r_acc <= w_prod_ext
                       + {{XC_EXT{w_xc[ffdl_pkg::SAMPLE_W]}}, w_xc,
                          ffdl_pkg::MIX_SHIFT'(ffdl_pkg::HALF_MIX)};
            end
            ffdl_pkg::S_WR:   r_wet <= ffdl_pkg::crush(r_yn, r_bit_depth);
            ffdl_pkg::S_HOLD: r_acc <= w_prod_ext + ffdl_pkg::HALF_MIX;
            ffdl_pkg::S_MIX1: r_acc <= r_acc + w_prod_ext;
            ffdl_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out <= ffdl_pkg::sat24(r_acc[ffdl_pkg::ACC_W-1:ffdl_pkg::MIX_SHIFT]);
                end
            end
            default: ;
        endcase
    end

    // Delay store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[w_rd_addr];
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ffdl_pkg::S_DONE))
        else $error("result raised outside the final step");

    a_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= LAST_ADDR) && (r_clr_addr <= LAST_ADDR))
        else $error("store pointer beyond depth");

endmodule

@@ bench/fractional_feedback_delay_line_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the fractional feedback delay line: a directed table of
// words and register writes, then random words, checked against hand-read results or a local predictor.
// Depends on hdl/ffdl_pkg.sv and hdl/fractional_feedback_delay_line.sv.

module fractional_feedback_delay_line_tb;
    import ffdl_pkg::*;

    localparam int unsigned STORE_DEPTH  = 131072;
    localparam int          RANDOM_WORDS = 750;
    localparam int          CALM_TAIL    = 80;
    localparam int          LONG_HOLD    = 300;
    localparam int          RUN_LIMIT    = 1000000;

    localparam t_sample PEAK_POS = 24'sh7fffff;
    localparam t_sample PEAK_NEG = 24'sh800000;

    typedef enum bit {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    // One row: a register write, or a word with an optional hand-read result
    typedef struct packed {
        t_row_kind   kind;
        t_cfg_index  sel;
        logic [16:0] val;
        t_sample     x;
        t_sample     c;
        logic [15:0] idx;
        bit          known;
        t_sample     want;
    } t_plan_row;

    localparam int PLAN_ROWS = 42;

    // Fields: kind, register, value, sample, cross-feed, index, known, result
    t_plan_row plan [PLAN_ROWS] = '{
        // reset settings: no wet signal, so the dry word comes straight out
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_POS, '0, 16'd0, 1'b1, PEAK_POS},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_NEG, PEAK_NEG, 16'd1, 1'b1, PEAK_NEG},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, '0, PEAK_POS, 16'd65535, 1'b1, '0},
        // zero delay, full wet: input passes through the wet path
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 17'd32768, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WET_LEVEL, 17'd32768, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh123456, '0, 16'd2, 1'b1, 24'sh123456},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_NEG, 24'sh0abcde, 16'd3, 1'b1, PEAK_NEG},
        // one-sample delay, then the largest fraction
        '{ROW_CFG, CFG_DELAY_SAMPLES, 17'd1, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh400000, PEAK_POS, 16'd4, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, -24'sd3000001, 24'sd77, 16'd5, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_FRACTION, 17'd65535, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh2aaaaa, -24'sd5, 16'd6, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, -24'sh155555, 24'sh7ff000, 16'd7, 1'b0, '0},
        // gains above one: dry weight goes negative, results saturate
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 17'd65535, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WET_LEVEL, 17'd65535, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_POS, PEAK_POS, 16'd8, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_NEG, PEAK_NEG, 16'd9, 1'b0, '0},
        // coarsest crusher step, depth past full scale, then depth one
        '{ROW_CFG, CFG_BIT_DEPTH, 17'd0, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, PEAK_NEG, '0, 16'd10, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh3fffff, 24'sh100000, 16'd11, 1'b0, '0},
        '{ROW_CFG, CFG_BIT_DEPTH, 17'd31, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh555555, '0, 16'd12, 1'b0, '0},
        '{ROW_CFG, CFG_BIT_DEPTH, 17'd1, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, -24'sh3abcde, 24'sh012345, 16'd13, 1'b0, '0},
        // sample hold by four across a run of indices
        '{ROW_CFG, CFG_RATE_DIVIDE, 17'd4, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_SAMPLES, 17'd3, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_WET_LEVEL, 17'd32768, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh111111, '0, 16'd16, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh222222, '0, 16'd17, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh333333, '0, 16'd18, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, -24'sh444444, '0, 16'd19, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh0f0f0f, '0, 16'd21, 1'b0, '0},
        // divisor zero never holds; largest divisor does
        '{ROW_CFG, CFG_RATE_DIVIDE, 17'd0, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh007654, '0, 16'd22, 1'b0, '0},
        '{ROW_CFG, CFG_RATE_DIVIDE, 17'd31, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh001234, '0, 16'd30, 1'b0, '0},
        // longest delay wraps the read behind the write pointer
        '{ROW_CFG, CFG_DELAY_SAMPLES, 17'd131071, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh654321, 24'sh800001, 16'd31, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, -24'sd1, 24'sd1, 16'd32, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_SAMPLES, 17'd2, '0, '0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_FRACTION, 17'd32768, '0, '0, '0, 1'b0, '0},
        '{ROW_WORD, CFG_DELAY_SAMPLES, '0, 24'sh0fffff, -24'sh0fffff, 16'd33, 1'b0, '0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_sample                i_sample_in;
    t_sample                i_cross_feed_in;
    logic [INDEX_W-1:0]     i_sample_index;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_sample                o_sample_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Register shadows and the echo store as the block should see them
    logic [16:0] cfg_delay;
    logic [15:0] cfg_fraction;
    logic [15:0] cfg_feedback;
    logic [15:0] cfg_wet;
    logic [4:0]  cfg_depth;
    logic [4:0]  cfg_rate;
    t_sample     echo_store [STORE_DEPTH];
    int unsigned wr_ptr;

    t_sample pending_mix [$];

    int  cycle_count   = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;
    int  mismatches    = 0;
    bit  bursts_on     = 1'b0;
    bit  stall_request = 1'b0;
    int  hold_left     = 0;
    int  gap_left      = 0;

    fractional_feedback_delay_line #(
        .DELAY_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_in     (i_sample_in),
        .i_cross_feed_in (i_cross_feed_in),
        .i_sample_index  (i_sample_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Divide by 2^sh, rounding to nearest with ties upward
    function automatic longint shift_round(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic t_sample clip_sample(longint v);
        if (v > longint'(PEAK_POS)) return PEAK_POS;
        if (v < longint'(PEAK_NEG)) return PEAK_NEG;
        return t_sample'(v);
    endfunction

    // Advance the echo store by one word and return the mixed output
    function automatic t_sample compute_mix(t_sample x_in, t_sample c_in, logic [15:0] idx);
        longint      x, c, y0, y1, yn, f, wet, mag, step;
        int unsigned p, d, r, r_prev;
        x = x_in;
        c = c_in;
        p = wr_ptr;
        d = cfg_delay;
        if (d > STORE_DEPTH - 1) d = STORE_DEPTH - 1;
        r      = (p >= d) ? (p - d) : (p + STORE_DEPTH - d);
        r_prev = (r == 0) ? (STORE_DEPTH - 1) : (r - 1);
        y0 = echo_store[r];
        y1 = echo_store[r_prev];

        // interpolate between the two taps, or pass the input at zero delay
        if (cfg_delay == 0) begin
            yn = x;
        end else begin
            f  = cfg_fraction;
            yn = shift_round(f * y1 + (65536 - f) * y0, 16);
        end
        echo_store[p] = clip_sample(x + shift_round(longint'(cfg_feedback) * yn, 15) + c);

        // truncate the wet value toward zero to the crusher step
        wet = yn;
        if (cfg_depth < FULL_DEPTH) begin
            step = longint'(1) << (23 - cfg_depth);
            mag  = (yn < 0) ? -yn : yn;
            mag  = mag - (mag % step);
            wet  = (yn < 0) ? -mag : mag;
        end
        // hold an earlier store entry on skipped indices
        if (cfg_rate > 1 && (int'(idx) % int'(cfg_rate)) != 0) begin
            wet = echo_store[r - (r % cfg_rate)];
        end

        wr_ptr = (p + 1 >= STORE_DEPTH) ? 0 : p + 1;
        return clip_sample(shift_round(longint'(cfg_wet) * wet
                                       + (32768 - longint'(cfg_wet)) * x, 15));
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return t_sample'(int'($urandom_range(0, 4095)) - 2048);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd32768;
            2: return 17'($urandom_range(32769, 65535));
            default: return 17'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic flag_mismatch(string what, t_sample want, t_sample got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected %0d (0x%06h), got %0d (0x%06h)",
                     $time, what, want, want, got, got);
        end
    endtask

    // Offer one word, hold it until taken, then record its expected output
    task automatic send_word(t_sample x, t_sample c, logic [15:0] idx,
                             bit known, t_sample want);
        t_sample predicted;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_sample_in     <= x;
        i_cross_feed_in <= c;
        i_sample_index  <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = compute_mix(x, c, idx);
        pending_mix.push_back(known ? want : predicted);
        words_sent++;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic settle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index which, logic [16:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (which)
            CFG_DELAY_SAMPLES:  cfg_delay    = val[16:0];
            CFG_DELAY_FRACTION: cfg_fraction = val[15:0];
            CFG_FEEDBACK_GAIN:  cfg_feedback = val[15:0];
            CFG_WET_LEVEL:      cfg_wet      = val[15:0];
            CFG_BIT_DEPTH:      cfg_depth    = val[4:0];
            CFG_RATE_DIVIDE:    cfg_rate     = val[4:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Pick a fresh setting for a random share of the registers
    task automatic retune();
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0: write_reg(CFG_DELAY_SAMPLES, 17'd0);
                1: write_reg(CFG_DELAY_SAMPLES, 17'd131071);
                2: write_reg(CFG_DELAY_SAMPLES, 17'($urandom));
                default: write_reg(CFG_DELAY_SAMPLES, 17'($urandom_range(1, 48)));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_DELAY_FRACTION, 17'd0);
                1: write_reg(CFG_DELAY_FRACTION, 17'd65535);
                default: write_reg(CFG_DELAY_FRACTION, 17'($urandom_range(0, 65535)));
            endcase
        end
        if ($urandom_range(0, 1)) write_reg(CFG_FEEDBACK_GAIN, pick_gain());
        if ($urandom_range(0, 1)) write_reg(CFG_WET_LEVEL, pick_gain());
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0: write_reg(CFG_BIT_DEPTH, 17'd0);
                1: write_reg(CFG_BIT_DEPTH, 17'($urandom_range(24, 31)));
                2, 3: write_reg(CFG_BIT_DEPTH, 17'd23);
                default: write_reg(CFG_BIT_DEPTH, 17'($urandom_range(1, 22)));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0: write_reg(CFG_RATE_DIVIDE, 17'd0);
                1: write_reg(CFG_RATE_DIVIDE, 17'($urandom_range(2, 31)));
                2: write_reg(CFG_RATE_DIVIDE, 17'($urandom_range(2, 4)));
                default: write_reg(CFG_RATE_DIVIDE, 17'd1);
            endcase
        end
    endtask

    // Output side: one long hold on request, otherwise short random stalls
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each output word with the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_mix.size() == 0) begin
                flag_mismatch("unexpected output word", '0, o_sample_out);
            end else begin
                want = pending_mix.pop_front();
                if (o_sample_out !== want) begin
                    flag_mismatch("sample_out mismatch", want, o_sample_out);
                end
            end
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) @(posedge i_clk);
        $display("** fractional_feedback_delay_line: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] idx;
        int          random_sent;
        int          phase_len;
        int          gap;
        bit          stall_done;

        idx         = '0;
        random_sent = 0;
        stall_done  = 1'b0;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_sample_in     = '0;
        i_cross_feed_in = '0;
        i_sample_index  = '0;
        i_out_ready     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;

        // clear the predictor to the reset state
        for (int k = 0; k < STORE_DEPTH; k++) echo_store[k] = '0;
        wr_ptr       = 0;
        cfg_delay    = '0;
        cfg_fraction = '0;
        cfg_feedback = '0;
        cfg_wet      = '0;
        cfg_depth    = FULL_DEPTH;
        cfg_rate     = 5'd1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // walk the directed table
        bursts_on = 1'b1;
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                settle();
                write_reg(plan[k].sel, plan[k].val);
            end else begin
                send_word(plan[k].x, plan[k].c, plan[k].idx, plan[k].known, plan[k].want);
            end
        end

        // random phases, each under a fresh register setting
        while (random_sent < RANDOM_WORDS) begin
            settle();
            retune();
            bursts_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 80);
            if (!stall_done && random_sent >= 300) begin
                stall_request = 1'b1;
                stall_done    = 1'b1;
            end
            repeat (phase_len) begin
                if (random_sent >= RANDOM_WORDS) break;
                if (random_sent >= RANDOM_WORDS - CALM_TAIL) bursts_on = 1'b0;
                if ($urandom_range(0, 15) == 0) idx = 16'($urandom);
                else idx = idx + 16'd1;
                send_word(pick_sample(), pick_sample(), idx, 1'b0, '0);
                random_sent++;
                if (bursts_on && $urandom_range(0, 3) == 0) begin
                    gap = $urandom_range(1, 12);
                    @(negedge i_clk) i_in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        mismatches += pending_mix.size();

        $display("Run: %0d words (%0d directed, %0d random), %0d register writes, %0d checked.",
                 words_sent, words_sent - random_sent, random_sent, reg_writes, results_seen);
        $display("Output held off once for %0d cycles with input back-pressured; %0d mismatches.",
                 LONG_HOLD, mismatches);
        if (mismatches == 0) begin
            $display("** fractional_feedback_delay_line: PASSED **");
        end else begin
            $display("** fractional_feedback_delay_line: FAILED **");
        end
        $finish;
    end

endmodule

@@ fractional_feedback_delay_line.f @@
hdl/ffdl_pkg.sv
hdl/fractional_feedback_delay_line.sv
bench/fractional_feedback_delay_line_tb.sv
